/* rtl/core/pta_pkg.sv */
// ----------------------------------------------------------------------------
// pta_pkg
// Types, constants and tables shared by the pixel to character ramp mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package pta_pkg;

   localparam int PALETTE_ENTRIES_RAW = 6;
   localparam int PAL_SLOTS  = 16;
   localparam int PALETTE_ENTRIES = (PALETTE_ENTRIES_RAW < 1) ? 1 :
                                    (PALETTE_ENTRIES_RAW > PAL_SLOTS) ? PAL_SLOTS :
                                    PALETTE_ENTRIES_RAW;
   localparam int PAL_IDX_W  = $clog2(PAL_SLOTS);
   localparam int PAL_LEVELS = PAL_IDX_W;
   localparam int DIST_W     = 18;
   localparam int IDX_W      = 7;
   localparam int PIPE_DEPTH = 6;

   localparam logic [DIST_W-1:0] DIST_PAD = {DIST_W{1'b1}};

   localparam logic [1:0] CSR_CHAR_STYLE     = 2'd0;
   localparam logic [1:0] CSR_COLOR_MODE     = 2'd1;
   localparam logic [1:0] CSR_PALETTE_ENABLE = 2'd2;

   typedef enum logic [1:0] {
      STYLE_SIMPLE   = 2'd0,
      STYLE_DETAILED = 2'd1,
      STYLE_BLOCKS   = 2'd2
   } char_style_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       row_end;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0] char_index;
      logic [7:0]       out_red;
      logic [7:0]       out_green;
      logic [7:0]       out_blue;
      logic             line_done;
   } rsp_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } color_type;

   typedef struct packed {
      char_style_type char_style;
      logic           color_mode;
      logic           palette_enable;
   } cfg_type;

   function automatic color_type pal_color(input logic [PAL_IDX_W-1:0] idx);
      color_type c;
      unique case (idx)
         4'd0:    c = '{8'd255, 8'd218, 8'd185};
         4'd1:    c = '{8'd255, 8'd192, 8'd203};
         4'd2:    c = '{8'd0,   8'd128, 8'd255};
         4'd3:    c = '{8'd0,   8'd0,   8'd0};
         4'd4:    c = '{8'd255, 8'd215, 8'd0};
         4'd5:    c = '{8'd255, 8'd99,  8'd71};
         default: c = '{8'd0,   8'd0,   8'd0};
      endcase
      return c;
   endfunction

   // Ramp levels minus one.
   function automatic logic [IDX_W-1:0] ramp_top(input char_style_type style);
      logic [IDX_W-1:0] t;
      unique case (style)
         STYLE_SIMPLE:   t = 7'd9;
         STYLE_DETAILED: t = 7'd69;
         STYLE_BLOCKS:   t = 7'd4;
         default:        t = 7'd9;
      endcase
      return t;
   endfunction

   function automatic logic [15:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] d;
      d = (a > b) ? (a - b) : (b - a);
      return 16'(d) * 16'(d);
   endfunction

endpackage

`default_nettype wire

/* rtl/core/pixel_to_ascii_palette_mapper.sv */
// ----------------------------------------------------------------------------
// pixel_to_ascii_palette_mapper
// Maps RGB pixels to a character ramp index and a background color.
//
// Requests enter on req_data when start is high and busy is low; busy stays
// low, so one pixel can enter every clock cycle. Each request yields exactly
// one response on rsp_data, marked by rsp_valid for one cycle, in request
// order. The response cannot be held off.
// Latency is set by the nearest-palette path: one stage of squared channel
// differences, one of distance sums and four levels of a registered minimum
// tree over the sixteen palette slots, plus the output register. The luma
// path (products, sum, scale, divide by 255) is padded to the same depth.
// The csr channel (csr_valid, csr_ready, csr_index, csr_wdata) writes the
// ramp style, color mode and palette enable; csr_ready is always high and
// writes to unknown indexes are dropped. Write registers only while no
// request is in flight. Synchronous reset clears the cfg_ff and valid
// registers to zero and drops all in-flight requests.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_to_ascii_palette_mapper (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire pta_pkg::req_type req_data,
   output logic                  rsp_valid,
   output pta_pkg::rsp_type      rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [1:0]       csr_index,
   input  wire logic [1:0]       csr_wdata
);

   typedef struct packed {
      pta_pkg::req_type pix;
      logic             color_mode;
      logic             palette_enable;
   } side_type;

   pta_pkg::cfg_type                cfg_ff;
   pta_pkg::cfg_type                cfg_in;
   logic [pta_pkg::PIPE_DEPTH:1]    valid_ff;
   side_type                        side_ff [pta_pkg::PIPE_DEPTH];
   logic                            rsp_valid_ff;
   pta_pkg::rsp_type                rsp_data_ff;
   pta_pkg::rsp_type                rsp_data_in;
   logic [pta_pkg::IDX_W-1:0]       char_index;
   logic [pta_pkg::PAL_IDX_W-1:0]   best;
   pta_pkg::color_type              pal;
   side_type                        last;
   logic                            accept;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            pta_pkg::CSR_CHAR_STYLE:     cfg_in.char_style = pta_pkg::char_style_type'(csr_wdata);
            pta_pkg::CSR_COLOR_MODE:     cfg_in.color_mode = csr_wdata[0];
            pta_pkg::CSR_PALETTE_ENABLE: cfg_in.palette_enable = csr_wdata[0];
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         valid_ff     <= {valid_ff[pta_pkg::PIPE_DEPTH-1:1], accept};
         rsp_valid_ff <= valid_ff[pta_pkg::PIPE_DEPTH];
      end
   end

   always_ff @(posedge clock) begin
      side_ff[0] <= '{req_data, cfg_ff.color_mode, cfg_ff.palette_enable};
      for (int i = 1; i < pta_pkg::PIPE_DEPTH; i++) begin
         side_ff[i] <= side_ff[i-1];
      end
      rsp_data_ff <= rsp_data_in;
   end

   pta_luma u_luma (
      .clock     (clock),
      .in_pix    (req_data),
      .in_top    (pta_pkg::ramp_top(cfg_ff.char_style)),
      .out_index (char_index)
   );

   pta_palette u_palette (
      .clock    (clock),
      .in_pix   (req_data),
      .out_best (best)
   );

   always_comb begin
      last = side_ff[pta_pkg::PIPE_DEPTH-1];
      pal  = pta_pkg::pal_color(best);
      rsp_data_in.char_index = char_index;
      rsp_data_in.line_done  = last.pix.row_end;
      if (!last.color_mode) begin
         rsp_data_in.out_red   = 8'd0;
         rsp_data_in.out_green = 8'd0;
         rsp_data_in.out_blue  = 8'd0;
      end else if (last.palette_enable) begin
         rsp_data_in.out_red   = pal.red;
         rsp_data_in.out_green = pal.green;
         rsp_data_in.out_blue  = pal.blue;
      end else begin
         rsp_data_in.out_red   = last.pix.red;
         rsp_data_in.out_green = last.pix.green;
         rsp_data_in.out_blue  = last.pix.blue;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

/* rtl/core/pta_luma.sv */
// ----------------------------------------------------------------------------
// pta_luma
// Six-stage luma and character ramp index pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module pta_luma (
   input  wire logic                      clock,
   input  wire pta_pkg::req_type          in_pix,
   input  wire logic [pta_pkg::IDX_W-1:0] in_top,
   output logic [pta_pkg::IDX_W-1:0]      out_index
);

   logic [20:0]               prod_r_ff;
   logic [21:0]               prod_g_ff;
   logic [18:0]               prod_b_ff;
   logic [pta_pkg::IDX_W-1:0] top1_ff;
   logic [pta_pkg::IDX_W-1:0] top2_ff;
   logic [7:0]                luma_ff;
   logic [14:0]               scaled_ff;
   logic [pta_pkg::IDX_W-1:0] top3_ff;
   logic [pta_pkg::IDX_W-1:0] idx4_ff;
   logic [pta_pkg::IDX_W-1:0] idx5_ff;
   logic [pta_pkg::IDX_W-1:0] idx6_ff;
   logic [22:0]               sum_in;
   logic [15:0]               quot_in;
   logic [pta_pkg::IDX_W-1:0] idx_in;

   always_comb begin
      sum_in  = 23'(prod_r_ff) + 23'(prod_g_ff) + 23'(prod_b_ff) + 23'd8192;
      // divide by 255, exact for the 15-bit dividends of scaled_ff
      quot_in = (16'(scaled_ff) + 16'(scaled_ff >> 8) + 16'd1) >> 8;
      idx_in  = (quot_in > 16'(top3_ff)) ? top3_ff : quot_in[pta_pkg::IDX_W-1:0];
   end

   always_ff @(posedge clock) begin
      prod_r_ff <= 21'(in_pix.red)   * 21'd4899;
      prod_g_ff <= 22'(in_pix.green) * 22'd9617;
      prod_b_ff <= 19'(in_pix.blue)  * 19'd1868;
      top1_ff   <= in_top;
      luma_ff   <= sum_in[21:14];
      top2_ff   <= top1_ff;
      scaled_ff <= 15'(luma_ff) * 15'(top2_ff);
      top3_ff   <= top2_ff;
      idx4_ff   <= idx_in;
      idx5_ff   <= idx4_ff;
      idx6_ff   <= idx5_ff;
   end

   assign out_index = idx6_ff;

endmodule

`default_nettype wire

/* rtl/core/pta_palette.sv */
// ----------------------------------------------------------------------------
// pta_palette
// Nearest palette entry: squared distances, then a registered minimum tree.
// ----------------------------------------------------------------------------
`default_nettype none

module pta_palette (
   input  wire logic                          clock,
   input  wire pta_pkg::req_type              in_pix,
   output logic [pta_pkg::PAL_IDX_W-1:0]      out_best
);

   pta_pkg::color_type pal_tab [pta_pkg::PAL_SLOTS];
   logic [15:0] sq_r_ff [pta_pkg::PAL_SLOTS];
   logic [15:0] sq_g_ff [pta_pkg::PAL_SLOTS];
   logic [15:0] sq_b_ff [pta_pkg::PAL_SLOTS];
   logic [pta_pkg::DIST_W-1:0]    dist_ff [pta_pkg::PAL_LEVELS+1][pta_pkg::PAL_SLOTS];
   logic [pta_pkg::PAL_IDX_W-1:0] idx_ff  [pta_pkg::PAL_LEVELS+1][pta_pkg::PAL_SLOTS];

   always_comb begin
      for (int i = 0; i < pta_pkg::PAL_SLOTS; i++) begin
         pal_tab[i] = pta_pkg::pal_color(pta_pkg::PAL_IDX_W'(i));
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < pta_pkg::PAL_SLOTS; i++) begin
         sq_r_ff[i] <= pta_pkg::sq_diff(in_pix.red,   pal_tab[i].red);
         sq_g_ff[i] <= pta_pkg::sq_diff(in_pix.green, pal_tab[i].green);
         sq_b_ff[i] <= pta_pkg::sq_diff(in_pix.blue,  pal_tab[i].blue);
      end
   end

   // Level zero: full distances, unused slots padded so they never win.
   always_ff @(posedge clock) begin
      for (int i = 0; i < pta_pkg::PAL_SLOTS; i++) begin
         if (i < pta_pkg::PALETTE_ENTRIES) begin
            dist_ff[0][i] <= pta_pkg::DIST_W'(sq_r_ff[i]) + pta_pkg::DIST_W'(sq_g_ff[i]) +
                             pta_pkg::DIST_W'(sq_b_ff[i]);
         end else begin
            dist_ff[0][i] <= pta_pkg::DIST_PAD;
         end
         idx_ff[0][i] <= pta_pkg::PAL_IDX_W'(i);
      end
   end

   // Lower index keeps ties.
   always_ff @(posedge clock) begin
      for (int l = 1; l <= pta_pkg::PAL_LEVELS; l++) begin
         for (int n = 0; n < (pta_pkg::PAL_SLOTS >> l); n++) begin
            if (dist_ff[l-1][2*n+1] < dist_ff[l-1][2*n]) begin
               dist_ff[l][n] <= dist_ff[l-1][2*n+1];
               idx_ff[l][n]  <= idx_ff[l-1][2*n+1];
            end else begin
               dist_ff[l][n] <= dist_ff[l-1][2*n];
               idx_ff[l][n]  <= idx_ff[l-1][2*n];
            end
         end
      end
   end

   assign out_best = idx_ff[pta_pkg::PAL_LEVELS][0];

endmodule

`default_nettype wire

/* rtl/core/pta_checker.sv */
// ----------------------------------------------------------------------------
// pta_checker
// Port-level checks of request to response timing and response contents.
// ----------------------------------------------------------------------------
`default_nettype none

module pta_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             start,
   input wire logic             busy,
   input wire pta_pkg::req_type req_data,
   input wire logic             rsp_valid,
   input wire pta_pkg::rsp_type rsp_data
);

   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 7))
      else $error("response without request");

   a_req_gets_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##7 rsp_valid)
      else $error("request without response");

   a_line_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.line_done == $past(req_data.row_end, 7)))
      else $error("line_done does not follow row_end");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.char_index <= 7'd69))
      else $error("char_index out of range");

endmodule

bind pixel_to_ascii_palette_mapper pta_checker u_pta_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

`default_nettype wire

/* bench/tb_pixel_to_ascii_palette_mapper.sv */
// ----------------------------------------------------------------------------
// tb_pixel_to_ascii_palette_mapper
// Self-checking bench for the pixel to character ramp mapper. Directed tests
// cover channel extremes, every ramp style, the unused style code, gray mode,
// color pass-through, exact and tied palette matches and writes to an unmapped
// register index. Random phases then stream pixels under varied settings,
// in bursts with random gaps. Each response is checked field by field against
// a prediction made when its request was accepted.
// ----------------------------------------------------------------------------
module tb_pixel_to_ascii_palette_mapper;
   import pta_pkg::*;

   localparam logic [1:0] CSR_UNMAPPED = 2'd3;
   localparam int PHASE_COUNT     = 10;
   localparam int PHASE_PIXELS    = 125;
   localparam int CYCLE_LIMIT     = 400000;

   logic       clock = 1'b0;
   logic       reset;
   logic       start;
   logic       busy;
   req_type    req_data;
   logic       rsp_valid;
   rsp_type    rsp_data;
   logic       csr_valid;
   logic       csr_ready;
   logic [1:0] csr_index;
   logic [1:0] csr_wdata;

   logic [1:0] cfg_style;
   logic       cfg_color;
   logic       cfg_palette;

   rsp_type    expected_glyphs[$];
   int         mismatch_count = 0;
   int         cycle_count = 0;

   pixel_to_ascii_palette_mapper dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic color_type swatch_color(input int slot);
      color_type c;
      case (slot)
         0:       c = '{8'd255, 8'd218, 8'd185};
         1:       c = '{8'd255, 8'd192, 8'd203};
         2:       c = '{8'd0,   8'd128, 8'd255};
         3:       c = '{8'd0,   8'd0,   8'd0};
         4:       c = '{8'd255, 8'd215, 8'd0};
         5:       c = '{8'd255, 8'd99,  8'd71};
         default: c = '{8'd0,   8'd0,   8'd0};
      endcase
      return c;
   endfunction

   function automatic int unsigned channel_gap_sq(input logic [7:0] a, input logic [7:0] b);
      int unsigned d;
      d = (a > b) ? (a - b) : (b - a);
      return d * d;
   endfunction

   function automatic rsp_type predict_glyph(input req_type px);
      rsp_type     g;
      color_type   sw;
      int unsigned luma;
      int unsigned top;
      int unsigned level;
      int unsigned sq_sum;
      int unsigned best_dist;
      int          best;
      luma = (4899 * int'(px.red) + 9617 * int'(px.green) + 1868 * int'(px.blue) + 8192)
             >> 14;
      case (cfg_style)
         STYLE_DETAILED: top = 69;
         STYLE_BLOCKS:   top = 4;
         default:        top = 9;
      endcase
      level = luma * top / 255;
      if (level > top) level = top;
      g = '0;
      g.char_index = IDX_W'(level);
      g.line_done  = px.row_end;
      if (cfg_color) begin
         g.out_red   = px.red;
         g.out_green = px.green;
         g.out_blue  = px.blue;
         if (cfg_palette) begin
            best      = 0;
            best_dist = 32'hFFFF_FFFF;
            for (int i = 0; i < PALETTE_ENTRIES; i++) begin
               sw     = swatch_color(i);
               sq_sum = channel_gap_sq(px.red, sw.red) + channel_gap_sq(px.green, sw.green) +
                        channel_gap_sq(px.blue, sw.blue);
               if (sq_sum < best_dist) begin
                  best_dist = sq_sum;
                  best      = i;
               end
            end
            sw          = swatch_color(best);
            g.out_red   = sw.red;
            g.out_green = sw.green;
            g.out_blue  = sw.blue;
         end
      end
      return g;
   endfunction

   function automatic req_type make_pixel(input int r, input int g, input int b,
                                          input logic last);
      req_type px;
      px.red     = 8'(r);
      px.green   = 8'(g);
      px.blue    = 8'(b);
      px.row_end = last;
      return px;
   endfunction

   function automatic int near_value(input int base, input int spread);
      int v;
      v = base + int'($urandom_range(0, 2 * spread)) - spread;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return v;
   endfunction

   function automatic req_type random_pixel();
      req_type   px;
      color_type a;
      color_type b;
      int        spread;
      px = req_type'($urandom);
      px.row_end = ($urandom_range(0, 7) == 0);
      case ($urandom_range(0, 9))
         5, 6: begin
            a      = swatch_color($urandom_range(0, PALETTE_ENTRIES - 1));
            spread = $urandom_range(0, 40);
            px.red   = 8'(near_value(a.red, spread));
            px.green = 8'(near_value(a.green, spread));
            px.blue  = 8'(near_value(a.blue, spread));
         end
         7: begin
            a      = swatch_color($urandom_range(0, PALETTE_ENTRIES - 1));
            b      = swatch_color($urandom_range(0, PALETTE_ENTRIES - 1));
            spread = $urandom_range(0, 2);
            px.red   = 8'(near_value((a.red + b.red) / 2, spread));
            px.green = 8'(near_value((a.green + b.green) / 2, spread));
            px.blue  = 8'(near_value((a.blue + b.blue) / 2, spread));
         end
         8: begin
            if ($urandom_range(0, 1)) px.red   = {8{px.red[0]}};
            if ($urandom_range(0, 1)) px.green = {8{px.green[0]}};
            if ($urandom_range(0, 1)) px.blue  = {8{px.blue[0]}};
         end
         9: begin
            px.green = px.red;
            px.blue  = px.red;
         end
         default: ;
      endcase
      return px;
   endfunction

   task automatic send_pixel(input req_type px);
      start    <= 1'b1;
      req_data <= px;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_glyphs = {expected_glyphs, predict_glyph(px)};
   endtask

   task automatic finish_requests();
      start <= 1'b0;
      while (expected_glyphs.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] idx, input logic [1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_CHAR_STYLE:     cfg_style   = value;
         CSR_COLOR_MODE:     cfg_color   = value[0];
         CSR_PALETTE_ENABLE: cfg_palette = value[0];
         default: ;
      endcase
   endtask

   // Write all registers while idle; the upper data bit of one-bit registers is random.
   task automatic program_mapper(input logic [1:0] style, input logic color, input logic pal,
                                 input logic poke_unmapped);
      while (expected_glyphs.size() != 0) @(posedge clock);
      write_register(CSR_CHAR_STYLE, style);
      write_register(CSR_COLOR_MODE, {1'($urandom), color});
      write_register(CSR_PALETTE_ENABLE, {1'($urandom), pal});
      if (poke_unmapped) write_register(CSR_UNMAPPED, 2'($urandom));
      csr_valid <= 1'b0;
   endtask

   task automatic run_pixels(input int count);
      int burst_left;
      int gap;
      burst_left = $urandom_range(1, 32);
      for (int i = 0; i < count; i++) begin
         send_pixel(random_pixel());
         burst_left--;
         if (burst_left == 0 && i != count - 1) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 4);
            if (gap > 0) begin
               start <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            burst_left = $urandom_range(1, 32);
         end
      end
      finish_requests();
   endtask

   task automatic test_reset_defaults();
      send_pixel(make_pixel(0, 0, 0, 1'b0));
      send_pixel(make_pixel(255, 255, 255, 1'b1));
      send_pixel(make_pixel(255, 0, 0, 1'b0));
      send_pixel(make_pixel(0, 255, 0, 1'b1));
      send_pixel(make_pixel(0, 0, 255, 1'b0));
      finish_requests();
   endtask

   task automatic test_ramp_styles();
      for (int s = 0; s < 4; s++) begin
         program_mapper(2'(s), 1'b0, 1'b0, 1'b0);
         send_pixel(make_pixel(255, 255, 255, 1'b1));
         send_pixel(make_pixel(128, 128, 128, 1'b0));
         finish_requests();
      end
   endtask

   task automatic test_color_passthrough();
      program_mapper(STYLE_DETAILED, 1'b1, 1'b0, 1'b0);
      send_pixel(make_pixel(17, 200, 93, 1'b0));
      send_pixel(make_pixel(255, 1, 254, 1'b1));
      finish_requests();
   endtask

   task automatic test_palette_snap();
      color_type sw;
      program_mapper(STYLE_BLOCKS, 1'b1, 1'b1, 1'b0);
      for (int i = 0; i < PALETTE_ENTRIES; i++) begin
         sw = swatch_color(i);
         send_pixel(make_pixel(sw.red, sw.green, sw.blue, 1'(i)));
      end
      // equidistant from the first two entries: the lower slot must win
      send_pixel(make_pixel(255, 205, 194, 1'b1));
      finish_requests();
   endtask

   task automatic test_gray_ignores_palette();
      program_mapper(STYLE_SIMPLE, 1'b0, 1'b1, 1'b0);
      send_pixel(make_pixel(255, 99, 71, 1'b1));
      finish_requests();
   endtask

   task automatic test_unmapped_index();
      program_mapper(STYLE_DETAILED, 1'b1, 1'b1, 1'b1);
      send_pixel(make_pixel(40, 180, 220, 1'b0));
      finish_requests();
   endtask

   task automatic test_random_phases();
      logic [1:0] style;
      logic       color;
      logic       pal;
      for (int p = 0; p < PHASE_COUNT; p++) begin
         case (p)
            0: {style, color, pal} = {STYLE_DETAILED, 1'b1, 1'b1};
            1: {style, color, pal} = {STYLE_SIMPLE,   1'b0, 1'b1};
            2: {style, color, pal} = {STYLE_BLOCKS,   1'b1, 1'b0};
            3: {style, color, pal} = {2'd3,           1'b1, 1'b1};
            4: {style, color, pal} = {STYLE_DETAILED, 1'b0, 1'b0};
            5: {style, color, pal} = {STYLE_BLOCKS,   1'b1, 1'b1};
            6: {style, color, pal} = {STYLE_SIMPLE,   1'b1, 1'b1};
            7: {style, color, pal} = {STYLE_DETAILED, 1'b1, 1'b0};
            default: {style, color, pal} = 4'($urandom);
         endcase
         program_mapper(style, color, pal, 1'($urandom));
         run_pixels(PHASE_PIXELS);
      end
   endtask

   task automatic check_field(input string field, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_glyphs.size() == 0) begin
            $display("%0t: unexpected response, expected none actual %h", $time, rsp_data);
            mismatch_count++;
         end else begin
            rsp_type want;
            want = expected_glyphs.pop_front();
            check_field("char_index", want.char_index, rsp_data.char_index);
            check_field("out_red", want.out_red, rsp_data.out_red);
            check_field("out_green", want.out_green, rsp_data.out_green);
            check_field("out_blue", want.out_blue, rsp_data.out_blue);
            check_field("line_done", want.line_done, rsp_data.line_done);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_pixel_to_ascii_palette_mapper NOT OK");
         $finish;
      end
   end

   initial begin
      reset       <= 1'b1;
      start       <= 1'b0;
      req_data    <= '0;
      csr_valid   <= 1'b0;
      csr_index   <= '0;
      csr_wdata   <= '0;
      cfg_style   = STYLE_SIMPLE;
      cfg_color   = 1'b0;
      cfg_palette = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_ramp_styles();
      test_color_passthrough();
      test_palette_snap();
      test_gray_ignores_palette();
      test_unmapped_index();
      test_random_phases();

      repeat (PIPE_DEPTH + 6) @(posedge clock);
      if (expected_glyphs.size() != 0) begin
         $display("%0t: responses missing, expected %0d actual 0", $time,
                  expected_glyphs.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("tb_pixel_to_ascii_palette_mapper OK");
      end else begin
         $display("tb_pixel_to_ascii_palette_mapper NOT OK");
      end
      $finish;
   end

endmodule
